[hdl/dexhc_pkg.sv]
// ----------------------------------------------------------------------------
// dexhc_pkg
// Constants for the executable image header and Adler-32 check.
// ----------------------------------------------------------------------------
package dexhc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned SUM_W   = 32;
	localparam int unsigned HALF_W  = 16;
	localparam int unsigned COUNT_W = 32;

	localparam logic [HALF_W-1:0]  ADLER_MOD  = 16'd65521;
	localparam logic [COUNT_W-1:0] HEADER_LEN = 32'd112;
	localparam logic [31:0]        ENDIAN_TAG = 32'h1234_5678;

	// magic and version characters
	localparam logic [BYTE_W-1:0] CH_D    = 8'h64;
	localparam logic [BYTE_W-1:0] CH_E    = 8'h65;
	localparam logic [BYTE_W-1:0] CH_X    = 8'h78;
	localparam logic [BYTE_W-1:0] CH_NL   = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
	localparam logic [BYTE_W-1:0] CH_3    = 8'h33;
	localparam logic [BYTE_W-1:0] CH_4    = 8'h34;
	localparam logic [BYTE_W-1:0] CH_5    = 8'h35;
	localparam logic [BYTE_W-1:0] CH_7    = 8'h37;
	localparam logic [BYTE_W-1:0] CH_8    = 8'h38;
	localparam logic [BYTE_W-1:0] CH_9    = 8'h39;

	// word slots, as byte offset divided by four
	localparam logic [29:0] SLOT_CHECKSUM = 30'd2;
	localparam logic [29:0] SLOT_SIZE     = 30'd8;
	localparam logic [29:0] SLOT_HDR_LEN  = 30'd9;
	localparam logic [29:0] SLOT_ENDIAN   = 30'd10;

	// first offset covered by the checksum
	localparam logic [COUNT_W-1:0] SUM_START = 32'd12;

	// result status codes
	localparam logic STATUS_PASS = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

endpackage

[hdl/dex_header_adler32_check.sv]
// ----------------------------------------------------------------------------
// dex_header_adler32_check
// Streaming header check and Adler-32 verify for one executable image.
// ----------------------------------------------------------------------------
// Usage:
//   Feed image bytes in file order on the s_ channel, one byte per item, with
//   s_tlast high on the final byte. Header fields (magic, version, header
//   length, endian tag) are checked as they pass, size at the last byte, and
//   an Adler-32 is kept over every byte from offset 12 on.
//   Only the last byte of an image produces a result on the m_ channel:
//   m_tuser is the status (0 pass, 1 fail), m_tdata the computed checksum.
//   After the result, all image state returns to its start values.
// Timing:
//   One byte per cycle sustained while no last byte waits on a pending result.
//   Each byte is held in the input register; the header compare and the two-add
//   Adler update lie between that register and the state/result registers.
//   m_tvalid rises as the last byte moves on into the result register.
// Reset and stall:
//   arst_n clears image state and valid bits (m_tvalid). While m_tvalid waits on
//   m_tready, non-last bytes keep flowing; a last byte of the next image is
//   held in the input register until the pending result is taken.
// ----------------------------------------------------------------------------
module dex_header_adler32_check
	import dexhc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
	input  logic              s_tlast,   // last_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [SUM_W-1:0]  m_tdata,   // [31:0] computed_checksum
	output logic [0:0]        m_tuser    // [0] status
);

	function automatic logic hdr_ok(
		input logic [COUNT_W-1:0] pos,
		input logic [BYTE_W-1:0]  b,
		input logic [BYTE_W-1:0]  vmid
	);
		logic        ok;
		logic [31:0] sh;
		ok = 1'b1;
		sh = '0;
		case (pos)
			32'd0: ok = (b == CH_D);
			32'd1: ok = (b == CH_E);
			32'd2: ok = (b == CH_X);
			32'd3: ok = (b == CH_NL);
			32'd4: ok = (b == CH_0);
			32'd5: ok = (b == CH_3) || (b == CH_4);
			32'd6: begin
				if (vmid == CH_3)
					ok = (b == CH_5) || (b == CH_7) || (b == CH_8) || (b == CH_9);
				else
					ok = (vmid == CH_4) && (b == CH_0);
			end
			32'd7: ok = (b == '0);
			default: begin
				if (pos[COUNT_W-1:2] == SLOT_HDR_LEN) begin
					sh = HEADER_LEN >> {pos[1:0], 3'b000};
					ok = (b == sh[BYTE_W-1:0]);
				end else if (pos[COUNT_W-1:2] == SLOT_ENDIAN) begin
					sh = ENDIAN_TAG >> {pos[1:0], 3'b000};
					ok = (b == sh[BYTE_W-1:0]);
				end
			end
		endcase
		return ok;
	endfunction

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// result register
	logic              valid_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic              status_s2;

	// image state
	logic [HALF_W-1:0]  low_q, high_q;
	logic [COUNT_W-1:0] count_q, declared_q;
	logic [SUM_W-1:0]   stored_q;
	logic [BYTE_W-1:0]  vmid_q;
	logic               fmt_ok_q;

	// next-state values
	logic [HALF_W-1:0]  low_n, high_n;
	logic [HALF_W:0]    low_sum, high_sum;
	logic [COUNT_W-1:0] count_n, declared_n;
	logic [SUM_W-1:0]   stored_n, sum_n;
	logic [BYTE_W-1:0]  vmid_n;
	logic               fmt_ok_n, pass_n;
	logic               advance;

	// a last byte needs the result register free
	assign advance  = valid_s1 && (!last_s1 || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		count_n    = count_q;
		fmt_ok_n   = fmt_ok_q;
		vmid_n     = vmid_q;
		stored_n   = stored_q;
		declared_n = declared_q;
		low_n      = low_q;
		high_n     = high_q;
		low_sum    = '0;
		high_sum   = '0;

		if (&count_q)
			fmt_ok_n = 1'b0;
		else
			count_n = count_q + 32'd1;

		if (count_q == 32'd5)
			vmid_n = byte_s1;
		if (!hdr_ok(count_q, byte_s1, vmid_q))
			fmt_ok_n = 1'b0;

		if (count_q[COUNT_W-1:2] == SLOT_CHECKSUM)
			stored_n[{count_q[1:0], 3'b000} +: BYTE_W] = byte_s1;
		if (count_q[COUNT_W-1:2] == SLOT_SIZE)
			declared_n[{count_q[1:0], 3'b000} +: BYTE_W] = byte_s1;

		if (count_q >= SUM_START) begin
			low_sum = {1'b0, low_q} + {{(HALF_W+1-BYTE_W){1'b0}}, byte_s1};
			if (low_sum >= {1'b0, ADLER_MOD})
				low_sum = low_sum - {1'b0, ADLER_MOD};
			low_n    = low_sum[HALF_W-1:0];
			high_sum = {1'b0, high_q} + {1'b0, low_n};
			if (high_sum >= {1'b0, ADLER_MOD})
				high_sum = high_sum - {1'b0, ADLER_MOD};
			high_n   = high_sum[HALF_W-1:0];
		end

		sum_n  = {high_n, low_n};
		pass_n = fmt_ok_n && (count_n >= HEADER_LEN) && (count_n == declared_n) &&
			(sum_n == stored_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q      <= 16'd1;
			high_q     <= '0;
			count_q    <= '0;
			fmt_ok_q   <= 1'b1;
			vmid_q     <= '0;
			stored_q   <= '0;
			declared_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				// start over for the next image
				low_q      <= 16'd1;
				high_q     <= '0;
				count_q    <= '0;
				fmt_ok_q   <= 1'b1;
				vmid_q     <= '0;
				stored_q   <= '0;
				declared_q <= '0;
			end else begin
				low_q      <= low_n;
				high_q     <= high_n;
				count_q    <= count_n;
				fmt_ok_q   <= fmt_ok_n;
				vmid_q     <= vmid_n;
				stored_q   <= stored_n;
				declared_q <= declared_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			sum_s2    <= sum_n;
			status_s2 <= pass_n ? STATUS_PASS : STATUS_FAIL;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = sum_s2;
	assign m_tuser  = status_s2;

endmodule

[hdl/dexhc_checker.sv]
// ----------------------------------------------------------------------------
// dexhc_checker
// Port-level checks for the image header and checksum block.
// ----------------------------------------------------------------------------
module dexhc_checker
	import dexhc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              s_tlast,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [SUM_W-1:0]  m_tdata,
	input logic [0:0]        m_tuser
);

	// no result on the edge after reset is seen
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// a last byte behind an untaken result must block the input
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && s_tvalid && s_tready && s_tlast |=>
		m_tready || !s_tready)
		else $error("input open while a second result has no room");

endmodule

bind dex_header_adler32_check dexhc_checker u_dexhc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
